>>> hdl/hlsi_pkg.sv
// Shared types and constants for the lattice site index generator.
// No dependencies; imported by hlsi_axis_class and halo_lattice_site_index.
`timescale 1ns / 1ps

package hlsi_pkg;

  // Lattice geometry limits
  localparam int MAX_SIDE = 1024;
  localparam int POS_W    = 12;
  localparam int SIZE_W   = 11;
  localparam int COORD_W  = 10;
  localparam int INDEX_W  = 31;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Per-axis position class
  localparam logic [1:0] CLS_IN  = 2'd0;
  localparam logic [1:0] CLS_LO  = 2'd1;
  localparam logic [1:0] CLS_HI  = 2'd2;
  localparam logic [1:0] CLS_OUT = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_SIZE_X = 3'd0;
  localparam logic [2:0] REG_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_HALO_X = 3'd3;
  localparam logic [2:0] REG_HALO_Y = 3'd4;
  localparam logic [2:0] REG_HALO_Z = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } hlsi_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] site_index;
    logic               invalid;
  } hlsi_out_t;

  // Classified coordinate of one axis
  typedef struct packed {
    logic [1:0]         cls;
    logic [COORD_W-1:0] coord;
    logic [SIZE_W-1:0]  size;
  } hlsi_axis_t;

endpackage

>>> hdl/hlsi_axis_class.sv
// Classifies one coordinate against the axis size: interior, low or high halo, outside.
// Applies size clamping and the periodic wrap. Depends on hlsi_pkg.
`timescale 1ns / 1ps

module hlsi_axis_class (
  input  logic signed [hlsi_pkg::POS_W-1:0]  pos,
  input  logic        [hlsi_pkg::SIZE_W-1:0] size_reg,
  input  logic                               halo,
  output hlsi_pkg::hlsi_axis_t               axis
);
  import hlsi_pkg::*;

  logic        [SIZE_W-1:0] eff_size;
  logic signed [POS_W:0]    pos_ext;
  logic signed [POS_W:0]    size_ext;
  logic signed [POS_W:0]    p;

  // Clamp the size into 1..MAX_SIDE
  always_comb begin
    if (size_reg == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_reg > SIZE_W'(MAX_SIDE)) begin
      eff_size = SIZE_W'(MAX_SIDE);
    end else begin
      eff_size = size_reg;
    end
  end

  assign pos_ext  = {pos[POS_W-1], pos};
  assign size_ext = $signed({2'b00, eff_size});

  // Wrap periodic axes, then classify
  always_comb begin
    p = pos_ext;
    if (!halo && pos_ext < 0) begin
      p = size_ext - 13'sd1;
    end else if (!halo && pos_ext == size_ext) begin
      p = '0;
    end

    axis.size  = eff_size;
    axis.coord = '0;
    if (p >= 0 && p < size_ext) begin
      axis.cls   = CLS_IN;
      axis.coord = p[COORD_W-1:0];
    end else if (p == -13'sd1) begin
      axis.cls = CLS_LO;
    end else if (p == size_ext) begin
      axis.cls = CLS_HI;
    end else begin
      axis.cls = CLS_OUT;
    end
  end

endmodule

>>> hdl/halo_lattice_site_index.sv
// Top level of the lattice site index generator: config registers and index pipeline.
// Depends on hlsi_pkg and hlsi_axis_class.
//
//   channel | direction | handshake                    | payload
//   in      | input     | in_valid / in_ready          | in_data  (hlsi_in_t)
//   out     | output    | out_valid / out_ready        | out_data (hlsi_out_t)
//   cfg     | input     | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One transaction enters per cycle while the output is not stalled; its result passes
// through the stage registers A, B and C and then into the output register.
// The four register stages are axis classification, the pairwise size products,
// the X*Y*Z volume with the region offset, and the final sum in the output register.
// Synchronous reset clears the valid bits and loads the register reset values.
// A stall at the output backs up stage by stage; empty stages still fill.
`timescale 1ns / 1ps

module halo_lattice_site_index (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hlsi_pkg::hlsi_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hlsi_pkg::hlsi_out_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hlsi_pkg::ADDR_W-1:0]   paddr,
  input  logic [hlsi_pkg::DATA_W-1:0]   pwdata,
  output logic [hlsi_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import hlsi_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic              halo_x_r, halo_y_r, halo_z_r;
  logic [2:0]        reg_sel;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write a register on the access phase; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
      halo_x_r <= 1'b0;
      halo_y_r <= 1'b0;
      halo_z_r <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SIZE_X: size_x_r <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_y_r <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_z_r <= pwdata[SIZE_W-1:0];
        REG_HALO_X: halo_x_r <= pwdata[0];
        REG_HALO_Y: halo_y_r <= pwdata[0];
        REG_HALO_Z: halo_z_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_SIZE_X: prdata = DATA_W'(size_x_r);
      REG_SIZE_Y: prdata = DATA_W'(size_y_r);
      REG_SIZE_Z: prdata = DATA_W'(size_z_r);
      REG_HALO_X: prdata = DATA_W'(halo_x_r);
      REG_HALO_Y: prdata = DATA_W'(halo_y_r);
      REG_HALO_Z: prdata = DATA_W'(halo_z_r);
      default:    prdata = '0;
    endcase
  end

  // Stage control: a stage advances when empty or when the next one advances
  logic a_v_r, b_v_r, c_v_r, out_valid_r;
  logic adv_a, adv_b, adv_c, adv_d;

  assign adv_d    = !out_valid_r || out_ready;
  assign adv_c    = !c_v_r || adv_d;
  assign adv_b    = !b_v_r || adv_c;
  assign adv_a    = !a_v_r || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_a) a_v_r       <= in_valid;
      if (adv_b) b_v_r       <= a_v_r;
      if (adv_c) c_v_r       <= b_v_r;
      if (adv_d) out_valid_r <= c_v_r;
    end
  end

  // Stage A: classify each axis
  hlsi_axis_t ax_nxt, ay_nxt, az_nxt;
  hlsi_axis_t a_x_r, a_y_r, a_z_r;
  logic [1:0] nb_nxt, a_nb_r;
  logic       inv_nxt, a_inv_r;

  hlsi_axis_class u_class_x (
    .pos(in_data.pos_x), .size_reg(size_x_r), .halo(halo_x_r), .axis(ax_nxt));
  hlsi_axis_class u_class_y (
    .pos(in_data.pos_y), .size_reg(size_y_r), .halo(halo_y_r), .axis(ay_nxt));
  hlsi_axis_class u_class_z (
    .pos(in_data.pos_z), .size_reg(size_z_r), .halo(halo_z_r), .axis(az_nxt));

  assign inv_nxt = (ax_nxt.cls == CLS_OUT) || (ay_nxt.cls == CLS_OUT) ||
                   (az_nxt.cls == CLS_OUT);
  assign nb_nxt  = 2'(ax_nxt.cls != CLS_IN) + 2'(ay_nxt.cls != CLS_IN) +
                   2'(az_nxt.cls != CLS_IN);

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      a_x_r   <= ax_nxt;
      a_y_r   <= ay_nxt;
      a_z_r   <= az_nxt;
      a_nb_r  <= nb_nxt;
      a_inv_r <= inv_nxt;
    end
  end

  // Stage B: pairwise size products and face-local offsets
  logic [21:0] xy_full, xz_full, yz_full;
  logic [21:0] ysum_full, xz_face_full, xy_face_full;
  logic [20:0] b_xy_r, b_xz_r, b_yz_r, b_ysum_r, b_xzf_r, b_xyf_r;
  hlsi_axis_t  b_x_r, b_y_r, b_z_r;
  logic [1:0]  b_nb_r;
  logic        b_inv_r;

  assign xy_full      = 22'(a_x_r.size) * 22'(a_y_r.size);
  assign xz_full      = 22'(a_x_r.size) * 22'(a_z_r.size);
  assign yz_full      = 22'(a_y_r.size) * 22'(a_z_r.size);
  assign ysum_full    = 22'(a_y_r.coord) + 22'(a_y_r.size) * 22'(a_z_r.coord);
  assign xz_face_full = 22'(a_x_r.coord) + 22'(a_x_r.size) * 22'(a_z_r.coord);
  assign xy_face_full = 22'(a_x_r.coord) + 22'(a_x_r.size) * 22'(a_y_r.coord);

  always_ff @(posedge clk) begin
    if (adv_b && a_v_r) begin
      b_xy_r   <= xy_full[20:0];
      b_xz_r   <= xz_full[20:0];
      b_yz_r   <= yz_full[20:0];
      b_ysum_r <= ysum_full[20:0];
      b_xzf_r  <= xz_face_full[20:0];
      b_xyf_r  <= xy_face_full[20:0];
      b_x_r    <= a_x_r;
      b_y_r    <= a_y_r;
      b_z_r    <= a_z_r;
      b_nb_r   <= a_nb_r;
      b_inv_r  <= a_inv_r;
    end
  end

  // Stage C: volume, interior index and halo offset past the interior
  logic [31:0] n_full, int_full;
  logic [23:0] e_off, sx, sy, sz, rel_nxt, base;
  logic [30:0] c_n_r, c_int_r;
  logic [23:0] c_rel_r;
  logic [1:0]  c_nb_r;
  logic        c_inv_r;

  assign n_full   = 32'(b_xy_r) * 32'(b_z_r.size);
  assign int_full = 32'(b_x_r.coord) + 32'(b_x_r.size) * 32'(b_ysum_r);
  assign e_off    = {2'b00, b_yz_r, 1'b0} + {2'b00, b_xz_r, 1'b0} + {2'b00, b_xy_r, 1'b0};
  assign sx       = 24'(b_x_r.size);
  assign sy       = 24'(b_y_r.size);
  assign sz       = 24'(b_z_r.size);

  // Pick the face, edge or corner region and add the local offset
  always_comb begin
    base    = '0;
    rel_nxt = '0;
    case (b_nb_r)
      2'd1: begin
        if (b_x_r.cls != CLS_IN) begin
          base    = (b_x_r.cls == CLS_LO) ? 24'd0 : 24'(b_yz_r);
          rel_nxt = base + 24'(b_ysum_r);
        end else if (b_y_r.cls != CLS_IN) begin
          base    = {2'b00, b_yz_r, 1'b0} +
                    ((b_y_r.cls == CLS_LO) ? 24'd0 : 24'(b_xz_r));
          rel_nxt = base + 24'(b_xzf_r);
        end else begin
          base    = {2'b00, b_yz_r, 1'b0} + {2'b00, b_xz_r, 1'b0} +
                    ((b_z_r.cls == CLS_LO) ? 24'd0 : 24'(b_xy_r));
          rel_nxt = base + 24'(b_xyf_r);
        end
      end
      2'd2: begin
        if (b_z_r.cls == CLS_IN) begin
          base    = (b_x_r.cls == CLS_LO) ? e_off : e_off + (sz << 1) + (sy << 1);
          rel_nxt = base + ((b_y_r.cls == CLS_HI) ? sz : 24'd0) + 24'(b_z_r.coord);
        end else if (b_y_r.cls == CLS_IN) begin
          base    = (b_x_r.cls == CLS_LO) ? e_off + (sz << 1)
                                          : e_off + (sz << 2) + (sy << 1);
          rel_nxt = base + ((b_z_r.cls == CLS_HI) ? sy : 24'd0) + 24'(b_y_r.coord);
        end else begin
          base    = e_off + (sz << 2) + (sy << 2);
          rel_nxt = base + ((b_y_r.cls == CLS_HI) ? (sx << 1) : 24'd0) +
                    ((b_z_r.cls == CLS_HI) ? sx : 24'd0) + 24'(b_x_r.coord);
        end
      end
      2'd3: begin
        base    = e_off + (sz << 2) + (sy << 2) + (sx << 2);
        rel_nxt = base + {21'd0, b_x_r.cls == CLS_HI, b_y_r.cls == CLS_HI,
                          b_z_r.cls == CLS_HI};
      end
      default: begin
        base    = '0;
        rel_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_c && b_v_r) begin
      c_n_r   <= n_full[30:0];
      c_int_r <= int_full[30:0];
      c_rel_r <= rel_nxt;
      c_nb_r  <= b_nb_r;
      c_inv_r <= b_inv_r;
    end
  end

  // Stage D: final sum into the output register
  hlsi_out_t   out_data_r, out_nxt;
  logic [31:0] halo_sum;

  assign halo_sum = 32'(c_n_r) + 32'(c_rel_r);

  always_comb begin
    out_nxt.invalid = c_inv_r;
    if (c_inv_r) begin
      out_nxt.site_index = '0;
    end else if (c_nb_r == 2'd0) begin
      out_nxt.site_index = c_int_r;
    end else begin
      out_nxt.site_index = halo_sum[INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_d && c_v_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.site_index == '0)
    else $error("invalid result carries a nonzero index");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> a_v_r && b_v_r && c_v_r && out_valid_r)
    else $error("input stalled while the pipeline has an empty stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> a_v_r)
    else $error("accepted transaction did not reach the first stage");

  a_interior_bound: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && !c_inv_r && c_nb_r == 2'd0 |-> c_int_r < c_n_r)
    else $error("interior index beyond the lattice volume");

endmodule
